[design/lmfde_pkg.sv]
// ----------------------------------------------------------------------------
// LED matrix draw engine package
// Command codes, result kinds and the control bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lmfde_pkg;

    localparam int BUF_W  = 2;
    localparam int PIX_W  = 6;
    localparam int KIND_W = 2;
    localparam int OP_W   = 4;

    // Command codes.
    localparam logic [OP_W-1:0] OP_FILL_ALL  = 4'd0;
    localparam logic [OP_W-1:0] OP_FILL_ROW  = 4'd1;
    localparam logic [OP_W-1:0] OP_FILL_COL  = 4'd2;
    localparam logic [OP_W-1:0] OP_FILL_PIX  = 4'd3;
    localparam logic [OP_W-1:0] OP_BMP_ALL   = 4'd4;
    localparam logic [OP_W-1:0] OP_BMP_ROW   = 4'd5;
    localparam logic [OP_W-1:0] OP_BMP_COL   = 4'd6;
    localparam logic [OP_W-1:0] OP_BMP_PIX   = 4'd7;
    localparam logic [OP_W-1:0] OP_SHOW_FILL = 4'd8;
    localparam logic [OP_W-1:0] OP_SHOW_PIX  = 4'd9;
    localparam logic [OP_W-1:0] OP_COPY      = 4'd10;
    localparam logic [OP_W-1:0] OP_SWAP      = 4'd11;
    localparam logic [OP_W-1:0] OP_SELECT    = 4'd12;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

    // Pixel walk shapes.
    localparam logic [1:0] SHAPE_ALL = 2'd0;
    localparam logic [1:0] SHAPE_ROW = 2'd1;
    localparam logic [1:0] SHAPE_COL = 2'd2;
    localparam logic [1:0] SHAPE_PIX = 2'd3;

    typedef struct packed {
        logic             load;   // latch the incoming command
        logic             issue;  // issue one pixel step
        logic [PIX_W-1:0] step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] last_step;
        logic             issue_ready;
        logic             busy;
    } t_dp_stat;

endpackage

[design/lmfde_ctrl.sv]
// ----------------------------------------------------------------------------
// LED matrix draw engine controller
// Accepts one command at a time and walks its pixel steps through the datapath.
// ----------------------------------------------------------------------------
module lmfde_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lmfde_pkg::t_dp_stat  i_stat,
    output lmfde_pkg::t_ctrl_cmd o_cmd
);

    localparam int PW = lmfde_pkg::PIX_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [lmfde_pkg::PIX_W-1:0] r_step, n_step;
    logic                        w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd.load  = w_accept;
        o_cmd.issue = 1'b0;
        o_cmd.step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.issue_ready) begin
                    if (r_step == i_stat.last_step) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_step = r_step + PW'(1);
                    end
                end
            end
            S_DRAIN: begin
                // Wait until the last step has left the read stage, so its
                // store write is done before the next command reads.
                if (!i_stat.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

[design/lmfde_dpath.sv]
// ----------------------------------------------------------------------------
// LED matrix draw engine datapath
// Command registers, buffer selection, pixel store, read stage and output
// register.
// ----------------------------------------------------------------------------
module lmfde_dpath #(
    parameter int BUF_COUNT = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lmfde_pkg::t_ctrl_cmd        i_cmd,
    output lmfde_pkg::t_dp_stat         o_stat,
    input  logic [lmfde_pkg::OP_W-1:0]  i_operation,
    input  logic signed [7:0]           i_x_pos,
    input  logic signed [7:0]           i_y_pos,
    input  logic [7:0]                  i_attr_in,
    input  logic [7:0]                  i_red_in,
    input  logic [7:0]                  i_green_in,
    input  logic [7:0]                  i_blue_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lmfde_pkg::KIND_W-1:0] o_kind,
    output logic [lmfde_pkg::BUF_W-1:0] o_buffer_sel,
    output logic [lmfde_pkg::PIX_W-1:0] o_pixel_index,
    output logic [7:0]                  o_attr_out,
    output logic [7:0]                  o_red_out,
    output logic [7:0]                  o_green_out,
    output logic [7:0]                  o_blue_out,
    output logic [lmfde_pkg::BUF_W-1:0] o_shown_buffer,
    output logic [lmfde_pkg::BUF_W-1:0] o_work_buffer,
    output logic                        o_last
);

    localparam int DEPTH = BUF_COUNT * 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = AW - lmfde_pkg::PIX_W;
    localparam int unsigned SEL_RECIP = (65536 + BUF_COUNT - 1) / BUF_COUNT;

    localparam int KW = lmfde_pkg::KIND_W;
    localparam int BFW = lmfde_pkg::BUF_W;
    localparam int PW = lmfde_pkg::PIX_W;

    // ---------------- command decode ----------------
    logic          w_xon, w_yon;
    logic [KW-1:0] w_kind;
    logic [1:0]    w_shape;
    logic [PW-1:0] w_last_step;
    logic [24:0]   w_prod_a, w_prod_r;
    logic [7:0]    w_rem_a, w_rem_r;
    logic [BFW-1:0] n_shown, n_work;

    assign w_xon = (i_x_pos[7:3] == 5'd0);
    assign w_yon = (i_y_pos[7:3] == 5'd0);

    // Remainder by the buffer count through a reciprocal multiply.
    assign w_prod_a = 25'(i_attr_in) * 25'(SEL_RECIP);
    assign w_prod_r = 25'(i_red_in) * 25'(SEL_RECIP);
    assign w_rem_a  = i_attr_in - 8'(10'(w_prod_a[23:16]) * 10'(BUF_COUNT));
    assign w_rem_r  = i_red_in - 8'(10'(w_prod_r[23:16]) * 10'(BUF_COUNT));

    logic [BFW-1:0] r_shown, r_work;

    always_comb begin
        w_kind  = lmfde_pkg::KIND_NONE;
        w_shape = lmfde_pkg::SHAPE_PIX;
        n_shown = r_shown;
        n_work  = r_work;
        case (i_operation)
            lmfde_pkg::OP_FILL_ALL, lmfde_pkg::OP_BMP_ALL, lmfde_pkg::OP_COPY: begin
                w_kind  = lmfde_pkg::KIND_WRITE;
                w_shape = lmfde_pkg::SHAPE_ALL;
            end
            lmfde_pkg::OP_SHOW_FILL: begin
                w_kind  = lmfde_pkg::KIND_WRITE;
                w_shape = lmfde_pkg::SHAPE_ALL;
                n_shown = r_work;
                n_work  = r_shown;
            end
            lmfde_pkg::OP_FILL_ROW, lmfde_pkg::OP_BMP_ROW: begin
                w_kind  = w_yon ? lmfde_pkg::KIND_WRITE : lmfde_pkg::KIND_NONE;
                w_shape = lmfde_pkg::SHAPE_ROW;
            end
            lmfde_pkg::OP_FILL_COL, lmfde_pkg::OP_BMP_COL: begin
                w_kind  = w_xon ? lmfde_pkg::KIND_WRITE : lmfde_pkg::KIND_NONE;
                w_shape = lmfde_pkg::SHAPE_COL;
            end
            lmfde_pkg::OP_FILL_PIX, lmfde_pkg::OP_BMP_PIX, lmfde_pkg::OP_SHOW_PIX: begin
                w_kind = (w_xon && w_yon) ? lmfde_pkg::KIND_WRITE : lmfde_pkg::KIND_NONE;
            end
            lmfde_pkg::OP_SWAP: begin
                w_kind  = lmfde_pkg::KIND_SEL;
                n_shown = r_work;
                n_work  = r_shown;
            end
            lmfde_pkg::OP_SELECT: begin
                if (i_y_pos[1:0] != 2'b00) begin
                    w_kind = lmfde_pkg::KIND_SEL;
                end
                if (i_y_pos[0]) begin
                    n_shown = w_rem_a[BFW-1:0];
                end
                if (i_y_pos[1]) begin
                    n_work = w_rem_r[BFW-1:0];
                end
            end
            default: begin
                w_kind = lmfde_pkg::KIND_NONE;
            end
        endcase
    end

    always_comb begin
        w_last_step = '0;
        if (w_kind == lmfde_pkg::KIND_WRITE) begin
            case (w_shape)
                lmfde_pkg::SHAPE_ALL: w_last_step = PW'(63);
                lmfde_pkg::SHAPE_ROW: w_last_step = PW'(7);
                lmfde_pkg::SHAPE_COL: w_last_step = PW'(7);
                default:              w_last_step = '0;
            endcase
        end
    end

    // ---------------- command registers ----------------
    logic [KW-1:0]  r_kind;
    logic [1:0]     r_shape;
    logic           r_bitmap, r_copy, r_on_shown;
    logic [PW-1:0]  r_last_step;
    logic [2:0]     r_x, r_y;
    logic [7:0]     r_attr, r_red, r_green, r_blue;
    logic [BFW-1:0] r_wbuf, r_sbuf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= w_kind;
            r_shape     <= w_shape;
            r_bitmap    <= i_operation inside {lmfde_pkg::OP_BMP_ALL, lmfde_pkg::OP_BMP_ROW,
                                               lmfde_pkg::OP_BMP_COL, lmfde_pkg::OP_BMP_PIX};
            r_copy      <= (i_operation == lmfde_pkg::OP_COPY);
            r_on_shown  <= (i_operation == lmfde_pkg::OP_SHOW_PIX);
            r_last_step <= w_last_step;
            r_x         <= i_x_pos[2:0];
            r_y         <= i_y_pos[2:0];
            r_attr      <= i_attr_in;
            r_red       <= i_red_in;
            r_green     <= i_green_in;
            r_blue      <= i_blue_in;
            r_wbuf      <= r_work;
            r_sbuf      <= r_shown;
        end
    end

    // The selection takes its new value at once; results of this command
    // report the selection after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= '0;
            r_work  <= BFW'(1);
        end else if (i_cmd.load) begin
            r_shown <= n_shown;
            r_work  <= n_work;
        end
    end

    // ---------------- step issue ----------------
    logic           r_a_valid;
    logic           w_out_load, w_a_load;
    logic [PW-1:0]  w_pix;
    logic [2:0]     w_bit;
    logic [31:0]    w_color;
    logic [BFW-1:0] w_buf;

    assign w_out_load = r_a_valid && (!o_out_valid || !i_out_stall);
    assign w_a_load   = i_cmd.issue && (!r_a_valid || w_out_load);

    assign o_stat.issue_ready = !r_a_valid || w_out_load;
    assign o_stat.busy        = r_a_valid;
    assign o_stat.last_step   = r_last_step;

    // Bitmap bit 7 belongs to the first column or row.
    assign w_bit = 3'd7 - i_cmd.step[2:0];

    always_comb begin
        case (r_shape)
            lmfde_pkg::SHAPE_ALL: w_pix = i_cmd.step;
            lmfde_pkg::SHAPE_ROW: w_pix = {r_y, i_cmd.step[2:0]};
            lmfde_pkg::SHAPE_COL: w_pix = {i_cmd.step[2:0], r_x};
            default:              w_pix = {r_y, r_x};
        endcase
        w_buf = r_on_shown ? r_sbuf : r_wbuf;
        if (r_bitmap) begin
            w_color = {8'h00,
                       r_red[w_bit]   ? 8'hFF : 8'h00,
                       r_green[w_bit] ? 8'hFF : 8'h00,
                       r_blue[w_bit]  ? 8'hFF : 8'h00};
        end else begin
            w_color = {r_attr, r_red, r_green, r_blue};
        end
        if (r_kind != lmfde_pkg::KIND_WRITE) begin
            w_pix   = '0;
            w_buf   = '0;
            w_color = '0;
        end
    end

    // ---------------- read stage ----------------
    logic [KW-1:0]  r_a_kind;
    logic [BFW-1:0] r_a_buf;
    logic [PW-1:0]  r_a_pix;
    logic [31:0]    r_a_color;
    logic           r_a_copy, r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_load) begin
            r_a_valid <= 1'b1;
        end else if (w_out_load) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_kind  <= r_kind;
            r_a_buf   <= w_buf;
            r_a_pix   <= w_pix;
            r_a_color <= w_color;
            r_a_copy  <= r_copy && (r_kind == lmfde_pkg::KIND_WRITE);
            r_a_last  <= (i_cmd.step == r_last_step);
        end
    end

    // ---------------- pixel store ----------------
    logic [31:0]   mem [DEPTH];
    logic [DEPTH-1:0] r_mem_ok;
    logic [31:0]   r_rd_data;
    logic          r_rd_ok;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [31:0]   w_wr_data;
    logic          w_wr_en;

    assign w_rd_addr = {r_sbuf[BW-1:0], w_pix};
    assign w_wr_addr = {r_a_buf[BW-1:0], r_a_pix};
    assign w_wr_data = r_a_copy ? (r_rd_ok ? r_rd_data : 32'h0) : r_a_color;
    assign w_wr_en   = w_out_load && (r_a_kind == lmfde_pkg::KIND_WRITE);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_a_load) begin
            r_rd_data <= mem[w_rd_addr];
            r_rd_ok   <= r_mem_ok[w_rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_ok <= '0;
        end else if (w_wr_en) begin
            r_mem_ok[w_wr_addr] <= 1'b1;
        end
    end

    // ---------------- output register ----------------
    logic           r_out_valid;
    logic [KW-1:0]  r_out_kind;
    logic [BFW-1:0] r_out_buf, r_out_shown, r_out_work;
    logic [PW-1:0]  r_out_pix;
    logic [31:0]    r_out_word;
    logic           r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind  <= r_a_kind;
            r_out_buf   <= r_a_buf;
            r_out_pix   <= r_a_pix;
            r_out_word  <= w_wr_data;
            r_out_shown <= r_shown;
            r_out_work  <= r_work;
            r_out_last  <= r_a_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_buffer_sel   = r_out_buf;
    assign o_pixel_index  = r_out_pix;
    assign o_attr_out     = r_out_word[31:24];
    assign o_red_out      = r_out_word[23:16];
    assign o_green_out    = r_out_word[15:8];
    assign o_blue_out     = r_out_word[7:0];
    assign o_shown_buffer = r_out_shown;
    assign o_work_buffer  = r_out_work;
    assign o_last         = r_out_last;

    // ---------------- assertions ----------------
    a_other_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind != lmfde_pkg::KIND_WRITE) |->
            (r_out_buf == '0) && (r_out_pix == '0) && (r_out_word == '0))
        else $error("selection or empty beat carries pixel data");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_shown) < BUF_COUNT) && (32'(r_work) < BUF_COUNT))
        else $error("buffer selection beyond buffer count");

    a_write_buf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (32'(r_a_buf) < BUF_COUNT))
        else $error("pixel write to a buffer that does not exist");

    a_read_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_out_load |=> r_a_valid && $stable(r_a_pix) && $stable(r_a_last))
        else $error("blocked read stage lost or changed its step");

endmodule

[design/led_matrix_frame_draw_engine_top.sv]
// ----------------------------------------------------------------------------
// LED matrix frame draw engine
// Command engine for an 8x8 RGB matrix with several frame buffers.
//
// Input channel (i_in_valid / o_in_stall) takes one command beat. Output
// channel (o_out_valid / i_out_stall) returns one beat per pixel written, in
// ascending pixel order, or a single selection or empty beat; o_last marks
// the final beat of a command.
// A command is taken when the engine is idle. Its pixel steps are issued one
// per cycle while the output does not stall, through a registered pixel store
// read stage into the output register. While the receiver stalls, the output
// beat holds and the step walk pauses. The next command is taken while the
// last beat of the previous one still waits in the output register.
// Reset clears the pixel store (all buffers read zero), shows buffer 0 and
// works on buffer 1.
// ----------------------------------------------------------------------------
module led_matrix_frame_draw_engine_top #(
    parameter int BUF_COUNT = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lmfde_pkg::OP_W-1:0]   i_operation,
    input  logic signed [7:0]            i_x_pos,
    input  logic signed [7:0]            i_y_pos,
    input  logic [7:0]                   i_attr_in,
    input  logic [7:0]                   i_red_in,
    input  logic [7:0]                   i_green_in,
    input  logic [7:0]                   i_blue_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lmfde_pkg::KIND_W-1:0] o_kind,
    output logic [lmfde_pkg::BUF_W-1:0]  o_buffer_sel,
    output logic [lmfde_pkg::PIX_W-1:0]  o_pixel_index,
    output logic [7:0]                   o_attr_out,
    output logic [7:0]                   o_red_out,
    output logic [7:0]                   o_green_out,
    output logic [7:0]                   o_blue_out,
    output logic [lmfde_pkg::BUF_W-1:0]  o_shown_buffer,
    output logic [lmfde_pkg::BUF_W-1:0]  o_work_buffer,
    output logic                         o_last
);

    lmfde_pkg::t_ctrl_cmd w_cmd;
    lmfde_pkg::t_dp_stat  w_stat;

    lmfde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lmfde_dpath #(
        .BUF_COUNT (BUF_COUNT)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_operation    (i_operation),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_attr_in      (i_attr_in),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_buffer_sel   (o_buffer_sel),
        .o_pixel_index  (o_pixel_index),
        .o_attr_out     (o_attr_out),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_shown_buffer (o_shown_buffer),
        .o_work_buffer  (o_work_buffer),
        .o_last         (o_last)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame draw engine testbench
// Drives draw, bitmap, copy, swap and select commands into the engine and
// checks every returned beat against a cycle-free model of the frame buffers
// and the shown/working selection. Both channels idle in random bursts, the
// receiver holds off for a long stretch once, and the run ends with a
// stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BUF_COUNT = 4;
    localparam int OPW       = lmfde_pkg::OP_W;
    localparam int KINDW     = lmfde_pkg::KIND_W;
    localparam int BUFW      = lmfde_pkg::BUF_W;
    localparam int PIXW      = lmfde_pkg::PIX_W;

    typedef struct {
        logic [OPW-1:0] op;
        logic [7:0]     x_pos;
        logic [7:0]     y_pos;
        logic [7:0]     attr;
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
    } t_draw_cmd;

    typedef struct {
        logic [KINDW-1:0] kind;
        logic [BUFW-1:0]  buffer_sel;
        logic [PIXW-1:0]  pixel_index;
        logic [7:0]       attr;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [BUFW-1:0]  shown;
        logic [BUFW-1:0]  work;
        logic             last;
    } t_pixel_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OPW-1:0]      i_operation;
    logic signed [7:0]   i_x_pos;
    logic signed [7:0]   i_y_pos;
    logic [7:0]          i_attr_in;
    logic [7:0]          i_red_in;
    logic [7:0]          i_green_in;
    logic [7:0]          i_blue_in;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [KINDW-1:0]    o_kind;
    logic [BUFW-1:0]     o_buffer_sel;
    logic [PIXW-1:0]     o_pixel_index;
    logic [7:0]          o_attr_out;
    logic [7:0]          o_red_out;
    logic [7:0]          o_green_out;
    logic [7:0]          o_blue_out;
    logic [BUFW-1:0]     o_shown_buffer;
    logic [BUFW-1:0]     o_work_buffer;
    logic                o_last;

    // Model of the frame buffers and the buffer selection.
    logic [31:0]   frame_mem [0:255];
    logic [1:0]    shown_sel;
    logic [1:0]    work_sel;
    t_pixel_beat   cmd_beats[$];
    t_pixel_beat   pending_beats[$];

    int  mismatch_count = 0;
    bit  idle_enabled = 1'b1;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    led_matrix_frame_draw_engine_top #(
        .BUF_COUNT(BUF_COUNT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_attr_in      (i_attr_in),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_buffer_sel   (o_buffer_sel),
        .o_pixel_index  (o_pixel_index),
        .o_attr_out     (o_attr_out),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_shown_buffer (o_shown_buffer),
        .o_work_buffer  (o_work_buffer),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Frame buffer model
    // ------------------------------------------------------------------------
    function automatic void write_pixel(logic [1:0] bsel, logic [5:0] pix, logic [31:0] word);
        t_pixel_beat b;
        frame_mem[{bsel, pix}] = word;
        b.kind        = lmfde_pkg::KIND_WRITE;
        b.buffer_sel  = bsel;
        b.pixel_index = pix;
        b.attr        = word[31:24];
        b.red         = word[23:16];
        b.green       = word[15:8];
        b.blue        = word[7:0];
        cmd_beats.push_back(b);
    endfunction

    function automatic void push_status(logic [KINDW-1:0] kind);
        t_pixel_beat b;
        b = '{kind, 2'd0, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 2'd0, 2'd0, 1'b0};
        cmd_beats.push_back(b);
    endfunction

    // Bitmap bit 7 maps to column (or row) 0; lit channels go full on.
    function automatic logic [31:0] bitmap_word(t_draw_cmd c, int col_bit);
        logic [7:0] m;
        m = 8'h80 >> col_bit;
        return {8'h00, (c.red & m) != 0 ? 8'hFF : 8'h00,
                (c.green & m) != 0 ? 8'hFF : 8'h00, (c.blue & m) != 0 ? 8'hFF : 8'h00};
    endfunction

    function automatic void predict_command(t_draw_cmd c);
        logic [1:0]  wb, sb;
        logic [31:0] color;
        logic        xon, yon;
        cmd_beats.delete();
        wb    = work_sel;
        sb    = shown_sel;
        color = {c.attr, c.red, c.green, c.blue};
        xon   = c.x_pos[7:3] == 5'd0;
        yon   = c.y_pos[7:3] == 5'd0;
        case (c.op)
            lmfde_pkg::OP_FILL_ALL, lmfde_pkg::OP_SHOW_FILL: begin
                for (int i = 0; i < 64; i++) write_pixel(wb, 6'(i), color);
                if (c.op == lmfde_pkg::OP_SHOW_FILL) begin
                    shown_sel = wb;
                    work_sel  = sb;
                end
            end
            lmfde_pkg::OP_FILL_ROW: begin
                if (yon) for (int i = 0; i < 8; i++)
                    write_pixel(wb, {c.y_pos[2:0], 3'(i)}, color);
            end
            lmfde_pkg::OP_FILL_COL: begin
                if (xon) for (int i = 0; i < 8; i++)
                    write_pixel(wb, {3'(i), c.x_pos[2:0]}, color);
            end
            lmfde_pkg::OP_FILL_PIX: begin
                if (xon && yon) write_pixel(wb, {c.y_pos[2:0], c.x_pos[2:0]}, color);
            end
            lmfde_pkg::OP_BMP_ALL: begin
                for (int i = 0; i < 64; i++) write_pixel(wb, 6'(i), bitmap_word(c, i % 8));
            end
            lmfde_pkg::OP_BMP_ROW: begin
                if (yon) for (int i = 0; i < 8; i++)
                    write_pixel(wb, {c.y_pos[2:0], 3'(i)}, bitmap_word(c, i));
            end
            lmfde_pkg::OP_BMP_COL: begin
                if (xon) for (int i = 0; i < 8; i++)
                    write_pixel(wb, {3'(i), c.x_pos[2:0]}, bitmap_word(c, i));
            end
            lmfde_pkg::OP_BMP_PIX: begin
                if (xon && yon)
                    write_pixel(wb, {c.y_pos[2:0], c.x_pos[2:0]}, bitmap_word(c, 0));
            end
            lmfde_pkg::OP_SHOW_PIX: begin
                if (xon && yon) write_pixel(sb, {c.y_pos[2:0], c.x_pos[2:0]}, color);
            end
            lmfde_pkg::OP_COPY: begin
                for (int i = 0; i < 64; i++) write_pixel(wb, 6'(i), frame_mem[{sb, 6'(i)}]);
            end
            lmfde_pkg::OP_SWAP: begin
                shown_sel = wb;
                work_sel  = sb;
                push_status(lmfde_pkg::KIND_SEL);
            end
            lmfde_pkg::OP_SELECT: begin
                if (c.y_pos[1:0] != 2'b00) begin
                    if (c.y_pos[0]) shown_sel = 2'(c.attr % BUF_COUNT);
                    if (c.y_pos[1]) work_sel = 2'(c.red % BUF_COUNT);
                    push_status(lmfde_pkg::KIND_SEL);
                end
            end
            default: ;
        endcase
        if (cmd_beats.size() == 0) push_status(lmfde_pkg::KIND_NONE);
        foreach (cmd_beats[k]) begin
            cmd_beats[k].shown = shown_sel;
            cmd_beats[k].work  = work_sel;
            cmd_beats[k].last  = (k == cmd_beats.size() - 1);
            pending_beats.push_back(cmd_beats[k]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------------
    function automatic t_draw_cmd make_cmd(logic [OPW-1:0] op, logic [7:0] x, logic [7:0] y,
                                           logic [7:0] a, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
        t_draw_cmd c;
        c = '{op, x, y, a, r, g, b};
        return c;
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high.
    task automatic send_command(t_draw_cmd c);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= c.op;
        i_x_pos     <= c.x_pos;
        i_y_pos     <= c.y_pos;
        i_attr_in   <= c.attr;
        i_red_in    <= c.red;
        i_green_in  <= c.green;
        i_blue_in   <= c.blue;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_command(c);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_coord();
        if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 7));
    endfunction

    function automatic t_draw_cmd rand_command();
        t_draw_cmd c;
        int pick;
        c = make_cmd(lmfde_pkg::OP_FILL_PIX, rand_coord(), rand_coord(),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            case ($urandom_range(0, 3))
                0: c.op = lmfde_pkg::OP_FILL_ALL;
                1: c.op = lmfde_pkg::OP_BMP_ALL;
                2: c.op = lmfde_pkg::OP_SHOW_FILL;
                default: c.op = lmfde_pkg::OP_COPY;
            endcase
        end else if (pick < 18) begin
            c.op = OPW'($urandom_range(0, 15));
        end else begin
            case ($urandom_range(0, 8))
                0: c.op = lmfde_pkg::OP_FILL_ROW;
                1: c.op = lmfde_pkg::OP_FILL_COL;
                2: c.op = lmfde_pkg::OP_FILL_PIX;
                3: c.op = lmfde_pkg::OP_BMP_ROW;
                4: c.op = lmfde_pkg::OP_BMP_COL;
                5: c.op = lmfde_pkg::OP_BMP_PIX;
                6: c.op = lmfde_pkg::OP_SHOW_PIX;
                7: c.op = lmfde_pkg::OP_SWAP;
                default: c.op = lmfde_pkg::OP_SELECT;
            endcase
        end
        // Select reads raw y bits, so let it see the full byte.
        if (c.op == lmfde_pkg::OP_SELECT) c.y_pos = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Result channel: stall pattern and beat checking
    // ------------------------------------------------------------------------
    initial begin
        int run_left;
        run_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = 600;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (!idle_enabled) begin
                i_out_stall <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                run_left = $urandom_range(0, 16);
            end else begin
                i_out_stall <= 1'b0;
                run_left = $urandom_range(0, 40);
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel_beat e;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_beats.size() == 0) begin
                $error("beat with nothing expected: kind 0x%0h pixel 0x%0h",
                       o_kind, o_pixel_index);
                mismatch_count++;
            end else begin
                e = pending_beats.pop_front();
                check_field("kind", 32'(e.kind), 32'(o_kind));
                check_field("buffer_sel", 32'(e.buffer_sel), 32'(o_buffer_sel));
                check_field("pixel_index", 32'(e.pixel_index), 32'(o_pixel_index));
                check_field("attr_out", 32'(e.attr), 32'(o_attr_out));
                check_field("red_out", 32'(e.red), 32'(o_red_out));
                check_field("green_out", 32'(e.green), 32'(o_green_out));
                check_field("blue_out", 32'(e.blue), 32'(o_blue_out));
                check_field("shown_buffer", 32'(e.shown), 32'(o_shown_buffer));
                check_field("work_buffer", 32'(e.work), 32'(o_work_buffer));
                check_field("last", 32'(e.last), 32'(o_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_command(make_cmd(lmfde_pkg::OP_FILL_ALL, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_cmd(lmfde_pkg::OP_FILL_ROW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_cmd(lmfde_pkg::OP_FILL_ROW, 8'h7F, 8'h07, 8'h80, 8'h7F, 8'h01, 8'hFE));
        send_command(make_cmd(lmfde_pkg::OP_FILL_COL, 8'h00, 8'h80, 8'h55, 8'hAA, 8'h55, 8'hAA));
        send_command(make_cmd(lmfde_pkg::OP_FILL_COL, 8'h07, 8'h7F, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_command(make_cmd(lmfde_pkg::OP_FILL_PIX, 8'h07, 8'h07, 8'h12, 8'h34, 8'h56, 8'h78));
        // Coordinates off the matrix write nothing.
        send_command(make_cmd(lmfde_pkg::OP_FILL_ROW, 8'h00, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44));
        send_command(make_cmd(lmfde_pkg::OP_FILL_COL, 8'h7F, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44));
        send_command(make_cmd(lmfde_pkg::OP_FILL_PIX, 8'hFF, 8'h03, 8'h11, 8'h22, 8'h33, 8'h44));
        send_command(make_cmd(lmfde_pkg::OP_FILL_PIX, 8'h03, 8'h08, 8'h11, 8'h22, 8'h33, 8'h44));
        // Bitmaps ignore the attribute byte and write zero there.
        send_command(make_cmd(lmfde_pkg::OP_BMP_ALL, 8'h00, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hC3));
        send_command(make_cmd(lmfde_pkg::OP_BMP_ROW, 8'h00, 8'h02, 8'hFF, 8'h80, 8'h01, 8'hFF));
        send_command(make_cmd(lmfde_pkg::OP_BMP_COL, 8'h05, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h40));
        send_command(make_cmd(lmfde_pkg::OP_BMP_PIX, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hC0));
        send_command(make_cmd(lmfde_pkg::OP_SHOW_FILL, 8'h00, 8'h00, 8'h9C, 8'h01, 8'h02, 8'h03));
        send_command(make_cmd(lmfde_pkg::OP_SHOW_PIX, 8'h01, 8'h06, 8'hE7, 8'hFF, 8'h00, 8'h80));
        send_command(make_cmd(lmfde_pkg::OP_COPY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_cmd(lmfde_pkg::OP_SWAP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_cmd(lmfde_pkg::OP_SELECT, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_command(make_cmd(lmfde_pkg::OP_SELECT, 8'h00, 8'h02, 8'h00, 8'h06, 8'h00, 8'h00));
        send_command(make_cmd(lmfde_pkg::OP_SELECT, 8'h00, 8'hFC, 8'h01, 8'h01, 8'h00, 8'h00));
        // Shown and working on the same buffer, then copy onto itself.
        send_command(make_cmd(lmfde_pkg::OP_SELECT, 8'h00, 8'h03, 8'h02, 8'h02, 8'h00, 8'h00));
        send_command(make_cmd(lmfde_pkg::OP_COPY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        for (int op = lmfde_pkg::OP_SELECT + 1; op < (1 << OPW); op++)
            send_command(make_cmd(OPW'(op), 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_command(rand_command());
    endtask

    // The receiver holds off while full-matrix fills keep coming, so the
    // engine fills up and must stall its command input.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int n = 0; n < 8; n++)
            send_command(make_cmd(lmfde_pkg::OP_FILL_ALL, 8'h00, 8'h00,
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    endtask

    task automatic test_streaming(int count);
        idle_enabled = 1'b0;
        test_random(count);
    endtask

    initial begin
        int waited;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = lmfde_pkg::OP_FILL_ALL;
        i_x_pos     = '0;
        i_y_pos     = '0;
        i_attr_in   = '0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        foreach (frame_mem[k]) frame_mem[k] = 32'h0;
        shown_sel = 2'd0;
        work_sel  = 2'd1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(216);
        test_backpressure();
        test_streaming(30);
        i_in_valid <= 1'b0;

        waited = 0;
        while (pending_beats.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (pending_beats.size() != 0) begin
            $error("%0d expected beats never arrived", pending_beats.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

[led_matrix_frame_draw_engine_top.f]
design/lmfde_pkg.sv
design/lmfde_ctrl.sv
design/lmfde_dpath.sv
design/led_matrix_frame_draw_engine_top.sv
tb/sv/testbench.sv
